// ===== hdl/lpht_pkg.sv =====
package lpht_pkg;

    localparam logic [2:0] ACT_SET    = 3'd0;
    localparam logic [2:0] ACT_REF    = 3'd1;
    localparam logic [2:0] ACT_HAS    = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_SIZE   = 3'd4;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] key;
        logic [63:0] value;
        logic [63:0] default_value;
    } req_t;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [63:0] data_out;
        logic [8:0]  entry_count_out;
    } rsp_t;

endpackage

// ===== hdl/lpht_ram.sv =====
module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/lpht_hash.sv =====
module lpht_hash #(
    parameter int AW = 8
) (
    input  logic          aclk,
    input  logic          start,
    input  logic [63:0]   key,
    output logic [AW-1:0] slot
);

    logic [63:0] lo_reg;
    logic [31:0] hi_reg;

    // The slot needs only the bits below AW of the product.
    always_ff @(posedge aclk) begin
        if (start) begin
            lo_reg <= {32'd0, key[31:0]} * {32'd0, lpht_pkg::HASH_MUL};
            hi_reg <= key[63:32] * lpht_pkg::HASH_MUL;
        end
    end

    logic [63:0] prod;
    assign prod = lo_reg + {hi_reg, 32'd0};
    assign slot = prod[AW-1:0];

endmodule

// ===== hdl/linear_probe_hash_table_core.sv =====
// Key/value table with open addressing and linear probing for 64-bit keys and
// values. One transaction is taken at a time. After reset a clearing pass
// wipes the occupancy memory before the first transaction. A lookup hashes the
// key, then reads and checks each probed slot in turn; a remove also walks the
// rest of the cluster, re-probing each later entry, so its cost grows with the
// cluster length. The single-port read path of the slot memories sets the pace.
module linear_probe_hash_table_core #(
    parameter int CAPACITY = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action, key, value, default_value from bit 0 up
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, found, data_out, entry_count_out from bit 0 up
    output logic [79:0]  m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LIMIT = CW'((CAPACITY * 3 + 3) / 4);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_HASH   = 11'b00000000100,
        S_RD     = 11'b00000001000,
        S_CHK    = 11'b00000010000,
        S_RM_RD  = 11'b00000100000,
        S_RM_CHK = 11'b00001000000,
        S_RE_HSH = 11'b00010000000,
        S_RE_RD  = 11'b00100000000,
        S_RE_CHK = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    lpht_pkg::req_t req_reg;
    lpht_pkg::rsp_t rsp_reg;
    logic [AW-1:0] slot_reg, nx_reg, clr_reg;
    logic [CW-1:0] cnt_reg, n_reg;
    logic [63:0] mk_reg, mv_reg;

    logic [AW-1:0] home, raddr, waddr;
    logic [63:0] rkey, rval, kw, vw;
    logic rocc, kwe, vwe, owe, owd;
    logic [199:0] req_bits;
    logic hash_start;
    logic [63:0] hkey;

    assign req_bits = s_tdata;
    assign m_tdata = {5'd0, rsp_reg.entry_count_out, rsp_reg.data_out, rsp_reg.found,
                      rsp_reg.status};

    lpht_hash #(.AW(AW)) u_hash (
        .aclk(aclk), .start(hash_start), .key(hkey), .slot(home)
    );
    lpht_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_key (
        .aclk(aclk), .we(kwe), .waddr(waddr), .wdata(kw), .raddr(raddr), .rdata(rkey)
    );
    lpht_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_val (
        .aclk(aclk), .we(vwe), .waddr(waddr), .wdata(vw), .raddr(raddr), .rdata(rval)
    );
    lpht_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_occ (
        .aclk(aclk), .we(owe), .waddr(waddr), .wdata(owd), .raddr(raddr), .rdata(rocc)
    );

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] s);
        return (s == LAST) ? '0 : s + 1'b1;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    logic hit, miss;
    assign miss = !rocc;
    assign hit = rocc && (rkey == hkey);

    always_comb begin
        state_next = state_reg;
        hash_start = 1'b0;
        hkey = (state_reg == S_RE_HSH || state_reg == S_RE_RD || state_reg == S_RE_CHK)
            ? mk_reg : req_reg.key;
        raddr = slot_reg;
        waddr = slot_reg;
        kwe = 1'b0; vwe = 1'b0; owe = 1'b0; owd = 1'b0;
        kw = req_reg.key; vw = req_reg.value;
        if (state_reg == S_IDLE) begin
            hkey = req_bits[66:3];
        end
        unique case (state_reg)
            S_CLEAR: begin
                owe = 1'b1; waddr = clr_reg;
                if (clr_reg == LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                raddr = home;
                state_next = (req_reg.action <= lpht_pkg::ACT_REMOVE) ? S_RD : S_OUT;
            end
            S_RD: state_next = S_CHK;
            S_CHK: begin
                if (hit || miss || n_reg == CW'(CAPACITY - 1)) begin
                    state_next = S_OUT;
                    if (hit && req_reg.action == lpht_pkg::ACT_SET) vwe = 1'b1;
                    if (miss && req_reg.action == lpht_pkg::ACT_SET && cnt_reg < LIMIT) begin
                        kwe = 1'b1; vwe = 1'b1; owe = 1'b1; owd = 1'b1;
                    end
                    if (hit && req_reg.action == lpht_pkg::ACT_REMOVE) begin
                        owe = 1'b1;
                        raddr = nxt(slot_reg);
                        state_next = S_RM_RD;
                    end
                end else begin
                    raddr = nxt(slot_reg);
                    state_next = S_RD;
                end
            end
            S_RM_RD: begin
                raddr = nx_reg;
                state_next = S_RM_CHK;
            end
            S_RM_CHK: begin
                if (!rocc || n_reg == CW'(CAPACITY)) begin
                    state_next = S_OUT;
                end else begin
                    owe = 1'b1; waddr = nx_reg;
                    hash_start = 1'b1; hkey = rkey;
                    state_next = S_RE_HSH;
                end
            end
            S_RE_HSH: begin
                raddr = home;
                state_next = S_RE_RD;
            end
            S_RE_RD: state_next = S_RE_CHK;
            S_RE_CHK: begin
                if (hit || miss) begin
                    kw = mk_reg; vw = mv_reg;
                    vwe = 1'b1;
                    if (miss) begin
                        kwe = 1'b1; owe = 1'b1; owd = 1'b1;
                    end
                    raddr = nxt(nx_reg);
                    state_next = S_RM_RD;
                end else begin
                    raddr = nxt(slot_reg);
                    state_next = S_RE_RD;
                end
            end
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + 1'b1;
                S_IDLE: begin
                    if (s_tvalid) begin
                        req_reg.action        <= req_bits[2:0];
                        req_reg.key           <= req_bits[66:3];
                        req_reg.value         <= req_bits[130:67];
                        req_reg.default_value <= req_bits[194:131];
                        rsp_reg <= '0;
                    end
                end
                S_HASH: begin
                    slot_reg <= home;
                    n_reg <= '0;
                    rsp_reg.entry_count_out <= 9'(cnt_reg);
                end
                S_RD: ;
                S_CHK: begin
                    if (hit || miss || n_reg == CW'(CAPACITY - 1)) begin
                        rsp_reg.found <= hit;
                        if (req_reg.action == lpht_pkg::ACT_REF) begin
                            rsp_reg.data_out <= hit ? rval : req_reg.default_value;
                        end
                        if (!hit && req_reg.action == lpht_pkg::ACT_SET) begin
                            if (miss && cnt_reg < LIMIT) begin
                                cnt_reg <= cnt_reg + 1'b1;
                                rsp_reg.entry_count_out <= 9'(cnt_reg + 1'b1);
                            end else begin
                                rsp_reg.status <= 1'b1;
                            end
                        end
                        if (hit && req_reg.action == lpht_pkg::ACT_REMOVE) begin
                            cnt_reg <= cnt_reg - 1'b1;
                            nx_reg <= nxt(slot_reg);
                            n_reg <= '0;
                        end
                    end else begin
                        slot_reg <= nxt(slot_reg);
                        n_reg <= n_reg + 1'b1;
                    end
                end
                S_RM_RD: ;
                S_RM_CHK: begin
                    if (!rocc || n_reg == CW'(CAPACITY)) begin
                        rsp_reg.entry_count_out <= 9'(cnt_reg);
                    end else begin
                        mk_reg <= rkey;
                        mv_reg <= rval;
                        n_reg <= n_reg + 1'b1;
                    end
                end
                S_RE_HSH: slot_reg <= home;
                S_RE_RD: ;
                S_RE_CHK: begin
                    if (hit || miss) begin
                        nx_reg <= nxt(nx_reg);
                    end else begin
                        slot_reg <= nxt(slot_reg);
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

endmodule

// ===== dv/lpht_checker.sv =====
module lpht_checker #(
    parameter int CAPACITY = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [79:0]  m_tdata,
    output int           fail_count,
    output int           pending
);
    import lpht_pkg::*;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [63:0] data_out;
        logic [8:0]  entry_count_out;
    } table_resp_t;

    logic [63:0] tbl_key [CAPACITY];
    logic [63:0] tbl_val [CAPACITY];
    bit          tbl_used [CAPACITY];
    int          tbl_count;
    table_resp_t resp_queue [$];

    initial fail_count = 0;
    assign pending = resp_queue.size();

    function automatic int slot_of(logic [63:0] k);
        logic [63:0] h;
        h = k * 64'(HASH_MUL);
        return int'(h % CAPACITY);
    endfunction

    // Returns 1 when the key is present; free_ok tells whether a free slot ended the walk.
    function automatic bit lookup(logic [63:0] k, output int slot, output bit free_ok);
        int s;
        s = slot_of(k);
        free_ok = 0;
        slot = 0;
        for (int n = 0; n < CAPACITY; n++) begin
            if (!tbl_used[s]) begin
                free_ok = 1;
                slot = s;
                return 0;
            end
            if (tbl_key[s] == k) begin
                slot = s;
                return 1;
            end
            s = (s + 1) % CAPACITY;
        end
        return 0;
    endfunction

    function automatic void reinsert(logic [63:0] k, logic [63:0] v);
        int s;
        bit fr;
        if (lookup(k, s, fr)) begin
            tbl_val[s] = v;
        end else if (fr) begin
            tbl_used[s] = 1;
            tbl_key[s] = k;
            tbl_val[s] = v;
            tbl_count++;
        end
    endfunction

    function automatic table_resp_t apply_request(req_t rq);
        table_resp_t r;
        int s, nx;
        bit fr;
        r = '0;
        case (rq.action)
            ACT_SET: begin
                if (lookup(rq.key, s, fr)) begin
                    r.found = 1;
                    tbl_val[s] = rq.value;
                end else if (tbl_count * 4 >= CAPACITY * 3 || !fr) begin
                    r.status = 1;
                end else begin
                    tbl_used[s] = 1;
                    tbl_key[s] = rq.key;
                    tbl_val[s] = rq.value;
                    tbl_count++;
                end
            end
            ACT_REF: begin
                if (lookup(rq.key, s, fr)) begin
                    r.found = 1;
                    r.data_out = tbl_val[s];
                end else begin
                    r.data_out = rq.default_value;
                end
            end
            ACT_HAS: r.found = lookup(rq.key, s, fr);
            ACT_REMOVE: begin
                if (lookup(rq.key, s, fr)) begin
                    r.found = 1;
                    tbl_used[s] = 0;
                    tbl_count--;
                    nx = (s + 1) % CAPACITY;
                    for (int n = 0; n < CAPACITY && tbl_used[nx]; n++) begin
                        tbl_used[nx] = 0;
                        tbl_count--;
                        reinsert(tbl_key[nx], tbl_val[nx]);
                        nx = (nx + 1) % CAPACITY;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count_out = 9'(tbl_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        req_t        rq;
        table_resp_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < CAPACITY; i++) tbl_used[i] = 0;
            tbl_count = 0;
            resp_queue.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                rq.action        = s_tdata[2:0];
                rq.key           = s_tdata[66:3];
                rq.value         = s_tdata[130:67];
                rq.default_value = s_tdata[194:131];
                resp_queue.push_back(apply_request(rq));
            end
            if (m_tvalid && m_tready) begin
                got.status          = m_tdata[0];
                got.found           = m_tdata[1];
                got.data_out        = m_tdata[65:2];
                got.entry_count_out = m_tdata[74:66];
                if (resp_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", 64'(got), 0);
                end else begin
                    want = resp_queue.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.found !== want.found)
                        report_mismatch("found", 64'(got.found), 64'(want.found));
                    if (got.data_out !== want.data_out)
                        report_mismatch("data_out", got.data_out, want.data_out);
                    if (got.entry_count_out !== want.entry_count_out)
                        report_mismatch("entry_count_out", 64'(got.entry_count_out),
                                        64'(want.entry_count_out));
                end
            end
        end
    end
endmodule

// ===== dv/tb_linear_probe_hash_table_core.sv =====
module tb_linear_probe_hash_table_core;
    import lpht_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           idle_pct;
    int           stall_pct;
    bit           hold_recv;
    logic [63:0]  key_pool [32];

    linear_probe_hash_table_core #(.CAPACITY(256)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    lpht_checker #(.CAPACITY(256)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            m_tready <= !hold_recv && ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send(logic [2:0] act, logic [63:0] k, logic [63:0] v, logic [63:0] d);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {5'd0, d, v, k, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic random_item(int dense);
        logic [63:0] k;
        int a;
        k = (dense != 0) ? key_pool[$urandom_range(31)] : rand64();
        a = $urandom_range(99);
        if (a < 5) send(3'($urandom_range(7, 5)), k, rand64(), rand64());
        else send(3'(a % 5), k, rand64(), rand64());
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        hold_recv = 0;
        idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 32; i++) key_pool[i] = rand64();
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send(ACT_SIZE, 0, 0, 0);
        send(ACT_REF, 0, 0, '1);
        send(ACT_HAS, '1, 0, 0);
        send(ACT_REMOVE, 0, 0, 0);
        send(ACT_SET, 0, '1, 0);
        send(ACT_SET, '1, 0, 0);
        send(ACT_SET, 0, 64'h1234, 0);
        send(ACT_REF, 0, 0, '1);
        send(ACT_REF, '1, '1, '1);
        send(ACT_HAS, 0, 0, 0);
        // Keys 0, 256 and 512 share a home slot and form one cluster.
        send(ACT_SET, 64'd256, 64'd7, 0);
        send(ACT_SET, 64'd512, 64'd8, 0);
        send(ACT_REMOVE, 0, 0, 0);
        send(ACT_REF, 64'd512, 0, 0);
        send(ACT_REMOVE, '1, 0, 0);
        send(3'd5, 1, 1, 1);
        send(3'd7, '1, '1, '1);
        send(ACT_SIZE, '1, '1, '1);
        drain();

        // Fill past the load limit so new keys are refused while updates still land.
        for (int i = 0; i < 200; i++) begin
            if (i == 60) begin
                fork
                    begin
                        hold_recv = 1;
                        repeat (300) @(posedge aclk);
                        hold_recv = 0;
                    end
                join_none
            end
            send(ACT_SET, rand64(), rand64(), 0);
        end
        send(ACT_SET, 64'd256, 64'd9, 0);
        send(ACT_SIZE, 0, 0, 0);
        for (int i = 0; i < 50; i++) random_item(0);
        drain();
        for (int i = 0; i < 32; i++) send(ACT_REMOVE, key_pool[i], 0, 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 57) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 57) : 0;
            for (int i = 0; i < 75; i++) random_item(i % 4 != 0);
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
